// ===== rtl/mfp_pkg.sv =====
// Shared constants and cell-to-cell payload types for the Mercator projection pipeline.
package mfp_pkg;

  // Default scene geometry
  localparam int ZOOM_DEF = 10;
  localparam int TILE_DEF = 256;

  // Fixed-point constants
  localparam logic [63:0] ONE_Q60    = 64'h1000_0000_0000_0000;
  localparam logic [63:0] TWO_Q60    = 64'h2000_0000_0000_0000;
  localparam logic [63:0] QUAD_Q60   = 64'h4000_0000_0000_0000;
  localparam logic [31:0] PI_LO      = 32'h885A_308D;
  localparam logic [29:0] PI_HI      = 30'h3243_F6A8;
  localparam logic [63:0] LN2_Q64    = 64'hB172_17F7_D1CF_79AB;
  localparam logic [63:0] INV2PI_Q64 = 64'h28BE_60DB_9391_054A;
  localparam logic [29:0] POLAR_LIMIT = 30'd360710144;  // 86 degrees
  localparam logic [63:0] MAG_MAX    = 64'h0000_0003_FFFF_FFFF;
  localparam logic [63:0] X_BIAS     = 64'd11520;
  localparam int unsigned X_DIV      = 23040;
  localparam int unsigned PHI_DIV    = 45;

  // Chain lengths
  localparam int TAYLOR_TERMS = 16;
  localparam int LOG_STEPS    = 60;
  localparam int NORM_STEPS   = 6;

  // Per-item data that rides alongside the arithmetic
  typedef struct packed {
    logic        lat_neg;
    logic        lon_neg;
    logic        polar;
    logic [33:0] x_mag;
  } side_t;

  typedef struct packed {
    logic [63:0] phi;
    side_t       sd;
  } phi_side_t;

  typedef struct packed {
    logic [63:0] a2;
    logic [63:0] ts;
    logic [63:0] tc;
    logic [63:0] ss;
    logic [63:0] sc;
  } taylor_t;

  typedef struct packed {
    taylor_t tay;
    side_t   sd;
  } tay_side_t;

  typedef struct packed {
    logic [63:0] s;
    logic [63:0] c;
    logic [5:0]  k;
  } norm_t;

  typedef struct packed {
    logic [63:0] m1;
    logic [63:0] m2;
    logic [63:0] r1;
    logic [63:0] r2;
    logic [5:0]  k;
  } log_t;

  typedef struct packed {
    log_t  lg;
    side_t sd;
  } log_side_t;

endpackage

// ===== rtl/mfp_mul64.sv =====
// Two-stage 64x64 multiplier built from four 32x32 partial products, with sideband delay.
module mfp_mul64 #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              vld_i,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [127:0]      prod,
  output logic [SIDE_W-1:0] side_o
);
  logic [63:0]       p00, p01, p10, p11;
  logic [SIDE_W-1:0] side_s1;
  logic              vld_s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s1 <= 1'b0;
      vld_o  <= 1'b0;
    end else begin
      vld_s1 <= vld_i;
      vld_o  <= vld_s1;
    end
  end

  always_ff @(posedge clk) begin
    p00     <= 64'(a[31:0])  * 64'(b[31:0]);
    p01     <= 64'(a[31:0])  * 64'(b[63:32]);
    p10     <= 64'(a[63:32]) * 64'(b[31:0]);
    p11     <= 64'(a[63:32]) * 64'(b[63:32]);
    side_s1 <= side_i;
    prod    <= {p11, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0};
    side_o  <= side_s1;
  end

endmodule

// ===== rtl/mfp_cdiv.sv =====
// Truncating division of a 64-bit value by a constant: reciprocal multiply and one correction.
module mfp_cdiv #(
  parameter int unsigned DIV    = 2,
  parameter int          SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              vld_i,
  input  logic [63:0]       v,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [63:0]       q,
  output logic [SIDE_W-1:0] side_o
);
  localparam logic [64:0] RECIP_FULL = (65'd1 << 64) / 65'(DIV);
  localparam logic [63:0] RECIP      = RECIP_FULL[63:0];
  localparam logic [63:0] DIV_W      = 64'(DIV);

  logic [127:0]         prod;
  logic [63+SIDE_W:0]   m_side;
  logic                 m_vld;
  logic [63:0]          q0, qd, v3, rem;
  logic [SIDE_W-1:0]    side3;
  logic                 vld3;

  mfp_mul64 #(.SIDE_W(64 + SIDE_W)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .vld_i  (vld_i),
    .a      (v),
    .b      (RECIP),
    .side_i ({v, side_i}),
    .vld_o  (m_vld),
    .prod   (prod),
    .side_o (m_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3  <= 1'b0;
      vld_o <= 1'b0;
    end else begin
      vld3  <= m_vld;
      vld_o <= vld3;
    end
  end

  assign rem = v3 - qd;

  // estimate is low by at most one
  always_ff @(posedge clk) begin
    q0     <= prod[127:64];
    qd     <= 64'(prod[127:64] * DIV_W);
    v3     <= m_side[63+SIDE_W:SIDE_W];
    side3  <= m_side[SIDE_W-1:0];
    q      <= (rem >= DIV_W) ? (q0 + 64'd1) : q0;
    side_o <= side3;
  end

endmodule

// ===== rtl/mfp_taylor_cell.sv =====
// One Taylor term of sine and cosine: multiply by angle squared, divide, accumulate.
module mfp_taylor_cell #(
  parameter int N = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              vld_i,
  input  mfp_pkg::taylor_t  tay_i,
  input  mfp_pkg::side_t    side_i,
  output logic              vld_o,
  output mfp_pkg::taylor_t  tay_o,
  output mfp_pkg::side_t    side_o
);
  import mfp_pkg::*;

  localparam int unsigned DIV_S = (2 * N) * (2 * N + 1);
  localparam int unsigned DIV_C = (2 * N - 1) * (2 * N);
  localparam bit          SUB   = (N % 2) == 1;

  logic [127:0] prod_s, prod_c;
  tay_side_t    ms, ds;
  logic         m_vld, d_vld;
  logic [63:0]  q_s, q_c;

  mfp_mul64 #(.SIDE_W($bits(tay_side_t))) u_mul_s (
    .clk(clk), .rst(rst), .vld_i(vld_i), .a(tay_i.ts), .b(tay_i.a2),
    .side_i({tay_i, side_i}), .vld_o(m_vld), .prod(prod_s), .side_o(ms)
  );

  mfp_mul64 #(.SIDE_W(1)) u_mul_c (
    .clk(clk), .rst(rst), .vld_i(vld_i), .a(tay_i.tc), .b(tay_i.a2),
    .side_i(1'b0), .vld_o(), .prod(prod_c), .side_o()
  );

  mfp_cdiv #(.DIV(DIV_S), .SIDE_W($bits(tay_side_t))) u_div_s (
    .clk(clk), .rst(rst), .vld_i(m_vld), .v(prod_s[123:60]),
    .side_i(ms), .vld_o(d_vld), .q(q_s), .side_o(ds)
  );

  mfp_cdiv #(.DIV(DIV_C), .SIDE_W(1)) u_div_c (
    .clk(clk), .rst(rst), .vld_i(m_vld), .v(prod_c[123:60]),
    .side_i(1'b0), .vld_o(), .q(q_c), .side_o()
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    tay_o.a2 <= ds.tay.a2;
    tay_o.ts <= q_s;
    tay_o.tc <= q_c;
    if (SUB) begin
      tay_o.ss <= ds.tay.ss - q_s;
      tay_o.sc <= ds.tay.sc - q_c;
    end else begin
      tay_o.ss <= ds.tay.ss + q_s;
      tay_o.sc <= ds.tay.sc + q_c;
    end
    side_o <= ds.sd;
  end

endmodule

// ===== rtl/mfp_norm_cell.sv =====
// One binary step of cosine normalization: shift left by a fixed amount when small.
module mfp_norm_cell #(
  parameter int SHIFT = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            vld_i,
  input  mfp_pkg::norm_t  norm_i,
  input  mfp_pkg::side_t  side_i,
  output logic            vld_o,
  output mfp_pkg::norm_t  norm_o,
  output mfp_pkg::side_t  side_o
);
  import mfp_pkg::*;

  localparam logic [63:0] LIMIT = 64'd1 << (61 - SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (norm_i.c < LIMIT) begin
      norm_o.c <= norm_i.c << SHIFT;
      norm_o.k <= norm_i.k + 6'(SHIFT);
    end else begin
      norm_o.c <= norm_i.c;
      norm_o.k <= norm_i.k;
    end
    norm_o.s <= norm_i.s;
    side_o   <= side_i;
  end

endmodule

// ===== rtl/mfp_log_cell.sv =====
// One squaring step of two parallel log2 evaluations, producing one result bit each.
module mfp_log_cell #(
  parameter int I = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           vld_i,
  input  mfp_pkg::log_t  log_i,
  input  mfp_pkg::side_t side_i,
  output logic           vld_o,
  output mfp_pkg::log_t  log_o,
  output mfp_pkg::side_t side_o
);
  import mfp_pkg::*;

  localparam logic [63:0] RBIT = 64'd1 << (60 - I);

  logic [127:0] prod1, prod2;
  log_side_t    ms;
  logic         m_vld;
  logic [63:0]  sq1, sq2;

  mfp_mul64 #(.SIDE_W($bits(log_side_t))) u_mul1 (
    .clk(clk), .rst(rst), .vld_i(vld_i), .a(log_i.m1), .b(log_i.m1),
    .side_i({log_i, side_i}), .vld_o(m_vld), .prod(prod1), .side_o(ms)
  );

  mfp_mul64 #(.SIDE_W(1)) u_mul2 (
    .clk(clk), .rst(rst), .vld_i(vld_i), .a(log_i.m2), .b(log_i.m2),
    .side_i(1'b0), .vld_o(), .prod(prod2), .side_o()
  );

  assign sq1 = prod1[123:60];
  assign sq2 = prod2[123:60];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (sq1 >= TWO_Q60) begin
      log_o.m1 <= sq1 >> 1;
      log_o.r1 <= ms.lg.r1 | RBIT;
    end else begin
      log_o.m1 <= sq1;
      log_o.r1 <= ms.lg.r1;
    end
    if (sq2 >= TWO_Q60) begin
      log_o.m2 <= sq2 >> 1;
      log_o.r2 <= ms.lg.r2 | RBIT;
    end else begin
      log_o.m2 <= sq2;
      log_o.r2 <= ms.lg.r2;
    end
    log_o.k <= ms.lg.k;
    side_o  <= ms.sd;
  end

endmodule

// ===== rtl/mercator_forward_projection.sv =====
// Top level: spherical Mercator forward projection, fully pipelined chain of cells.
// Throughput: one point per cycle; busy is always low, set by the fixed-depth cell chain.
// The long path is 16 Taylor cells (7 stages each) and 60 log2 squaring cells (3 each).
// Reset (rst, synchronous, active high) clears all valid bits; data registers hold no reset.
// The receiver cannot stall: each result is shown with done for exactly one cycle.
module mercator_forward_projection #(
  parameter int ZOOM_LEVEL_BASE = mfp_pkg::ZOOM_DEF,
  parameter int TILE_PIXELS     = mfp_pkg::TILE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [29:0] latitude_deg,
  input  logic signed [30:0] longitude_deg,
  output logic               done,
  output logic signed [34:0] scene_x,
  output logic signed [34:0] scene_y,
  output logic               y_saturated
);
  import mfp_pkg::*;

  // scene length in pixels and half of it in 16 fraction bits
  localparam logic [63:0] LEN  = 64'(TILE_PIXELS) << ZOOM_LEVEL_BASE;
  localparam logic [63:0] HALF = LEN << 15;

  // ---------------------------------------------------------------
  // Input stage: take magnitudes and signs, flag polar latitudes.
  // ---------------------------------------------------------------
  logic [29:0] lat_u, lat_mag;
  logic [30:0] lon_u, lon_mag;
  logic        lat_neg0, lon_neg0, polar0, vld0;

  assign busy  = 1'b0;
  assign lat_u = latitude_deg;
  assign lon_u = longitude_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else begin
      vld0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    lat_neg0 <= lat_u[29];
    lon_neg0 <= lon_u[30];
    lat_mag  <= lat_u[29] ? 30'(~lat_u + 30'd1) : lat_u;
    lon_mag  <= lon_u[30] ? 31'(~lon_u + 31'd1) : lon_u;
    polar0   <= (lat_u[29] ? 30'(~lat_u + 30'd1) : lat_u) >= POLAR_LIMIT;
  end

  // ---------------------------------------------------------------
  // Angle and x numerator: latitude times pi in two halves, longitude times scene length.
  // ---------------------------------------------------------------
  logic [61:0] pi_lo1;
  logic [59:0] pi_hi1;
  logic [63:0] lon_v1, lon_v2, phi_v2;
  logic [91:0] lat_pi;
  logic        lat_neg1, lon_neg1, polar1, vld1;
  logic        lat_neg2, lon_neg2, polar2, vld2;

  assign lat_pi = 92'(pi_lo1) + (92'(pi_hi1) << 32);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      vld1 <= vld0;
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    pi_lo1   <= 62'(lat_mag) * 62'(PI_LO);
    pi_hi1   <= 60'(lat_mag) * 60'(PI_HI);
    lon_v1   <= 64'(64'(lon_mag) * LEN) + X_BIAS;
    lat_neg1 <= lat_neg0;
    lon_neg1 <= lon_neg0;
    polar1   <= polar0;
    phi_v2   <= 64'(lat_pi[91:30]);
    lon_v2   <= lon_v1;
    lat_neg2 <= lat_neg1;
    lon_neg2 <= lon_neg1;
    polar2   <= polar1;
  end

  // divide the angle by 45 and the x numerator by 23040 side by side
  logic [63:0] phi_q, x_q;
  logic [1:0]  phi_side;
  logic        x_side;
  logic        vld_d;

  mfp_cdiv #(.DIV(PHI_DIV), .SIDE_W(2)) u_div_phi (
    .clk(clk), .rst(rst), .vld_i(vld2), .v(phi_v2), .side_i({lat_neg2, polar2}),
    .vld_o(vld_d), .q(phi_q), .side_o(phi_side)
  );

  mfp_cdiv #(.DIV(X_DIV), .SIDE_W(1)) u_div_x (
    .clk(clk), .rst(rst), .vld_i(vld2), .v(lon_v2), .side_i(lon_neg2),
    .vld_o(), .q(x_q), .side_o(x_side)
  );

  // ---------------------------------------------------------------
  // Scale the angle to radians in Q60, clamp x, then square the angle.
  // ---------------------------------------------------------------
  logic [63:0] phi3;
  side_t       side3;
  logic        vld3;
  logic [127:0] a2_prod;
  phi_side_t   a2_side;
  logic        a2_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= vld_d;
    end
  end

  always_ff @(posedge clk) begin
    phi3          <= phi_q << 6;
    side3.lat_neg <= phi_side[1];
    side3.polar   <= phi_side[0];
    side3.lon_neg <= x_side;
    side3.x_mag   <= (x_q > MAG_MAX) ? MAG_MAX[33:0] : x_q[33:0];
  end

  mfp_mul64 #(.SIDE_W($bits(phi_side_t))) u_mul_a2 (
    .clk(clk), .rst(rst), .vld_i(vld3), .a(phi3), .b(phi3),
    .side_i({phi3, side3}), .vld_o(a2_vld), .prod(a2_prod), .side_o(a2_side)
  );

  // ---------------------------------------------------------------
  // Sine and cosine: one Taylor cell per term.
  // ---------------------------------------------------------------
  taylor_t tay  [0:TAYLOR_TERMS];
  side_t   tsd  [0:TAYLOR_TERMS];
  logic    tvld [0:TAYLOR_TERMS];

  always_comb begin
    tay[0].a2 = a2_prod[123:60];
    tay[0].ts = a2_side.phi;
    tay[0].tc = ONE_Q60;
    tay[0].ss = a2_side.phi;
    tay[0].sc = ONE_Q60;
    tsd[0]    = a2_side.sd;
    tvld[0]   = a2_vld;
  end

  for (genvar n = 0; n < TAYLOR_TERMS; n++) begin : g_tay
    mfp_taylor_cell #(.N(n + 1)) u_cell (
      .clk(clk), .rst(rst), .vld_i(tvld[n]), .tay_i(tay[n]), .side_i(tsd[n]),
      .vld_o(tvld[n+1]), .tay_o(tay[n+1]), .side_o(tsd[n+1])
    );
  end

  // ---------------------------------------------------------------
  // Clamp sine into [0, 1) and cosine into [1 ulp, 1].
  // ---------------------------------------------------------------
  norm_t       nrm  [0:NORM_STEPS];
  side_t       nsd  [0:NORM_STEPS];
  logic        nvld [0:NORM_STEPS];
  logic [63:0] s_raw, c_raw, s_fix;

  assign s_raw = tay[TAYLOR_TERMS].ss;
  assign c_raw = tay[TAYLOR_TERMS].sc;
  assign s_fix = (s_raw > QUAD_Q60) ? 64'd0 : s_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      nvld[0] <= 1'b0;
    end else begin
      nvld[0] <= tvld[TAYLOR_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    nrm[0].s <= (s_fix >= ONE_Q60) ? (ONE_Q60 - 64'd1) : s_fix;
    if (c_raw > ONE_Q60) begin
      nrm[0].c <= ONE_Q60;
    end else if (c_raw == 64'd0) begin
      nrm[0].c <= 64'd1;
    end else begin
      nrm[0].c <= c_raw;
    end
    nrm[0].k <= 6'd0;
    nsd[0]   <= tsd[TAYLOR_TERMS];
  end

  // normalize cosine into [1,2) by shifts of 32, 16, 8, 4, 2, 1
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    mfp_norm_cell #(.SHIFT(32 >> j)) u_cell (
      .clk(clk), .rst(rst), .vld_i(nvld[j]), .norm_i(nrm[j]), .side_i(nsd[j]),
      .vld_o(nvld[j+1]), .norm_o(nrm[j+1]), .side_o(nsd[j+1])
    );
  end

  // ---------------------------------------------------------------
  // log2(1 + sin) and log2(cos * 2^k): one squaring cell per result bit.
  // ---------------------------------------------------------------
  log_t  lg   [0:LOG_STEPS];
  side_t lsd  [0:LOG_STEPS];
  logic  lvld [0:LOG_STEPS];

  always_comb begin
    lg[0].m1 = ONE_Q60 + nrm[NORM_STEPS].s;
    lg[0].m2 = nrm[NORM_STEPS].c;
    lg[0].r1 = 64'd0;
    lg[0].r2 = 64'd0;
    lg[0].k  = nrm[NORM_STEPS].k;
    lsd[0]   = nsd[NORM_STEPS];
    lvld[0]  = nvld[NORM_STEPS];
  end

  for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
    mfp_log_cell #(.I(i + 1)) u_cell (
      .clk(clk), .rst(rst), .vld_i(lvld[i]), .log_i(lg[i]), .side_i(lsd[i]),
      .vld_o(lvld[i+1]), .log_o(lg[i+1]), .side_o(lsd[i+1])
    );
  end

  // ---------------------------------------------------------------
  // psi in log2 units, then scale by ln2 and by 1/(2 pi).
  // ---------------------------------------------------------------
  logic [63:0]  d_val;
  side_t        d_side;
  logic         d_vld;
  logic [127:0] ln_prod, t_prod;
  side_t        ln_side, t_side;
  logic         ln_vld, t_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= lvld[LOG_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    d_val  <= lg[LOG_STEPS].r1 + (64'(lg[LOG_STEPS].k) << 60) - lg[LOG_STEPS].r2;
    d_side <= lsd[LOG_STEPS];
  end

  mfp_mul64 #(.SIDE_W($bits(side_t))) u_mul_ln2 (
    .clk(clk), .rst(rst), .vld_i(d_vld), .a(d_val), .b(LN2_Q64),
    .side_i(d_side), .vld_o(ln_vld), .prod(ln_prod), .side_o(ln_side)
  );

  mfp_mul64 #(.SIDE_W($bits(side_t))) u_mul_inv2pi (
    .clk(clk), .rst(rst), .vld_i(ln_vld), .a(ln_prod[127:64]), .b(INV2PI_Q64),
    .side_i(ln_side), .vld_o(t_vld), .prod(t_prod), .side_o(t_side)
  );

  // ---------------------------------------------------------------
  // Scale to pixels, round, clamp y and apply signs.
  // ---------------------------------------------------------------
  logic [127:0] y_prod;
  side_t        y_side;
  logic         y_vld;
  logic [63:0]  y_round;
  logic [63:0]  y_clip;
  logic         y_flag;
  logic [33:0]  y_mag;
  logic         y_sat5;
  side_t        side5;
  logic         vld5;
  logic [34:0]  x_ext, y_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      y_vld <= 1'b0;
      vld5  <= 1'b0;
      done  <= 1'b0;
    end else begin
      y_vld <= t_vld;
      vld5  <= y_vld;
      done  <= vld5;
    end
  end

  // scene length is a constant, so this product is shifts and adds
  always_ff @(posedge clk) begin
    y_prod <= 128'(t_prod[127:64]) * 128'(LEN);
    y_side <= t_side;
  end

  assign y_round = (y_prod[106:43] + 64'd1) >> 1;

  always_comb begin
    priority if (y_side.polar) begin
      y_clip = HALF;
      y_flag = 1'b1;
    end else if (y_round > HALF) begin
      y_clip = HALF;
      y_flag = 1'b1;
    end else begin
      y_clip = y_round;
      y_flag = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (y_clip > MAG_MAX) begin
      y_mag  <= MAG_MAX[33:0];
      y_sat5 <= 1'b1;
    end else begin
      y_mag  <= y_clip[33:0];
      y_sat5 <= y_flag;
    end
    side5 <= y_side;
  end

  assign x_ext = {1'b0, side5.x_mag};
  assign y_ext = {1'b0, y_mag};

  // y grows downward: northern latitudes give negative y
  always_ff @(posedge clk) begin
    scene_x     <= side5.lon_neg ? $signed(35'd0 - x_ext) : $signed(x_ext);
    scene_y     <= side5.lat_neg ? $signed(y_ext) : $signed(35'd0 - y_ext);
    y_saturated <= y_sat5;
  end

endmodule

// ===== sim/mercator_forward_projection_tb.sv =====
// Self-checking testbench for the Mercator forward projection: directed table, then random points.
module mercator_forward_projection_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Scene geometry matches the block's default parameters.
  localparam int unsigned ZOOM = mfp_pkg::ZOOM_DEF;
  localparam int unsigned TILE = mfp_pkg::TILE_DEF;
  localparam logic [63:0] MAP_SPAN   = (64'd1 << ZOOM) * TILE;
  localparam logic [63:0] HALF_SCENE = MAP_SPAN << 15;

  // Fixed-point constants, written out here so the checker stands apart from the RTL.
  localparam logic [63:0] Q60_ONE     = 64'h1000_0000_0000_0000;
  localparam logic [63:0] PI_Q60      = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] LN2_Q64     = 64'hB172_17F7_D1CF_79AB;
  localparam logic [63:0] INV2PI_Q64  = 64'h28BE_60DB_9391_054A;
  localparam logic [63:0] MAG_LIMIT   = (64'd1 << 34) - 1;
  localparam logic [29:0] POLAR_EDGE  = 30'd86 << 22;

  // Field extremes in raw degrees (22 fraction bits).
  localparam int LAT_90  = 377487360;
  localparam int LON_180 = 754974720;

  localparam int NUM_RANDOM    = 1130;
  localparam int WATCHDOG_MAX  = 5000;
  localparam int DRAIN_CYCLES  = 340;

  typedef struct packed {
    logic signed [34:0] x;
    logic signed [34:0] y;
    logic               sat;
  } scene_pt_t;

  // One directed row: a point, and optionally the result typed in by hand.
  typedef struct {
    logic signed [29:0] lat;
    logic signed [30:0] lon;
    bit                 typed;
    scene_pt_t          pt;
  } probe_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [29:0] latitude_deg;
  logic signed [30:0] longitude_deg;
  logic               done;
  logic signed [34:0] scene_x;
  logic signed [34:0] scene_y;
  logic               y_saturated;

  mercator_forward_projection dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .latitude_deg  (latitude_deg),
    .longitude_deg (longitude_deg),
    .done          (done),
    .scene_x       (scene_x),
    .scene_y       (scene_y),
    .y_saturated   (y_saturated)
  );

  scene_pt_t pending_pts[$];    // results still owed by the block, oldest first
  scene_pt_t typed_pts[$];      // hand-typed results for the directed rows, in order of transfer
  bit        typed_flags[$];
  int        mismatches = 0;
  int        idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // (a * b) >> sh over the full 128-bit product, kept to 64 bits.
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod >> sh);
  endfunction

  // log2 of a Q60 mantissa in [1,2) by repeated squaring.
  function automatic logic [63:0] log2_q60(logic [63:0] m);
    logic [63:0] r;
    r = '0;
    for (int i = 1; i <= 60; i++) begin
      m = mul_shift(m, m, 60);
      if (m >= (Q60_ONE << 1)) begin
        m = m >> 1;
        r[60 - i] = 1'b1;
      end
    end
    return r;
  endfunction

  // Expected scene point for one geographic point.
  function automatic scene_pt_t project_point(logic signed [29:0] lat, logic signed [30:0] lon);
    logic        lat_neg, lon_neg, sat;
    logic [29:0] lat_mag;
    logic [30:0] lon_mag;
    logic [63:0] x_mag, y_mag, phi, a2, ts, tc, sn, cs, d, t;
    logic [5:0]  k;
    scene_pt_t   pt;
    lat_neg = lat[29];
    lon_neg = lon[30];
    lat_mag = lat_neg ? 30'(-lat) : lat;
    lon_mag = lon_neg ? 31'(-lon) : lon;
    sat = 1'b0;

    // Longitude: lon/360 * L, rounded half away from zero, then clamped.
    x_mag = (64'(lon_mag) * MAP_SPAN + 64'd11520) / 64'd23040;
    if (x_mag > MAG_LIMIT) x_mag = MAG_LIMIT;

    if (lat_mag >= POLAR_EDGE) begin
      y_mag = HALF_SCENE;
      sat = 1'b1;
    end else begin
      phi = (mul_shift(64'(lat_mag), PI_Q60, 30) / 64'd45) << 6;
      // Truncated Taylor series for sin and cos.
      a2 = mul_shift(phi, phi, 60);
      ts = phi;
      tc = Q60_ONE;
      sn = phi;
      cs = Q60_ONE;
      for (int n = 1; n <= 16; n++) begin
        ts = mul_shift(ts, a2, 60) / 64'((2 * n) * (2 * n + 1));
        tc = mul_shift(tc, a2, 60) / 64'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          sn = sn - ts;
          cs = cs - tc;
        end else begin
          sn = sn + ts;
          cs = cs + tc;
        end
      end
      if (sn > (64'd1 << 62)) sn = '0;
      if (sn >= Q60_ONE) sn = Q60_ONE - 1;
      if (cs > Q60_ONE) cs = Q60_ONE;
      if (cs == '0) cs = 64'd1;
      k = '0;
      while (cs < Q60_ONE) begin
        cs = cs << 1;
        k++;
      end
      // psi = ln(1 + sin) - ln(cos), scaled by 1/(2 pi).
      d = log2_q60(Q60_ONE + sn) + (64'(k) << 60) - log2_q60(cs);
      t = mul_shift(mul_shift(d, LN2_Q64, 64), INV2PI_Q64, 64);
      y_mag = (mul_shift(t, MAP_SPAN, 43) + 64'd1) >> 1;
      if (y_mag > HALF_SCENE) begin
        y_mag = HALF_SCENE;
        sat = 1'b1;
      end
    end
    if (y_mag > MAG_LIMIT) begin
      y_mag = MAG_LIMIT;
      sat = 1'b1;
    end

    pt.x   = lon_neg ? -35'(x_mag) : 35'(x_mag);
    pt.y   = lat_neg ? 35'(y_mag) : -35'(y_mag);   // screen y grows southward
    pt.sat = sat;
    return pt;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Monitor: check each strobed result against the oldest expectation, then
  // record the point transferred at this edge. Also run the stall watchdog.
  always @(posedge clk) begin
    scene_pt_t want;
    if (!rst) begin
      if (done) begin
        if (pending_pts.size() == 0) begin
          report_mismatch("unexpected result, x", scene_x, 0);
        end else begin
          want = pending_pts.pop_front();
          if (scene_x !== want.x) report_mismatch("scene_x", scene_x, want.x);
          if (scene_y !== want.y) report_mismatch("scene_y", scene_y, want.y);
          if (y_saturated !== want.sat) report_mismatch("y_saturated", y_saturated, want.sat);
        end
      end
      if (start && !busy) begin
        if (typed_flags.pop_front()) pending_pts.push_back(typed_pts.pop_front());
        else pending_pts.push_back(project_point(latitude_deg, longitude_deg));
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Present one point from the falling edge and hold it until the transfer.
  task automatic send_point(logic signed [29:0] lat, logic signed [30:0] lon, bit typed,
                            scene_pt_t pt, bit may_idle);
    typed_flags.push_back(typed);
    if (typed) typed_pts.push_back(pt);
    if (may_idle && $urandom_range(0, 99) < 33) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    start         <= 1'b1;
    latitude_deg  <= lat;
    longitude_deg <= lon;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    probe_row_t        probes[$];
    probe_row_t        row;
    logic signed [29:0] lat;
    logic signed [30:0] lon;
    bit                 gaps;

    rst           = 1'b1;
    start         = 1'b0;
    latitude_deg  = '0;
    longitude_deg = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows. Typed results: origin, date line, poles and field limits.
    probes.push_back('{30'sd0, 31'sd0, 1, '{35'sd0, 35'sd0, 1'b0}});
    probes.push_back('{30'sd0, 31'(LON_180), 1, '{35'sd1 <<< 33, 35'sd0, 1'b0}});
    probes.push_back('{30'sd0, -31'(LON_180), 1, '{-(35'sd1 <<< 33), 35'sd0, 1'b0}});
    probes.push_back('{30'(LAT_90), 31'sd0, 1, '{35'sd0, -(35'sd1 <<< 33), 1'b1}});
    probes.push_back('{-30'(LAT_90), 31'sd0, 1, '{35'sd0, 35'sd1 <<< 33, 1'b1}});
    probes.push_back('{30'(POLAR_EDGE), 31'sd0, 1, '{35'sd0, -(35'sd1 <<< 33), 1'b1}});
    probes.push_back('{-30'(POLAR_EDGE), 31'sd0, 1, '{35'sd0, 35'sd1 <<< 33, 1'b1}});
    // Beyond 90 degrees and the most negative raw values: polar clamp.
    probes.push_back('{30'h1FFF_FFFF, 31'h3FFF_FFFF, 0, '{default: '0}});
    probes.push_back('{30'h2000_0000, 31'h4000_0000, 0, '{default: '0}});
    // Just under the polar edge, where the computed y may pass half the scene.
    probes.push_back('{30'(POLAR_EDGE) - 30'sd1, 31'sd1, 0, '{default: '0}});
    probes.push_back('{-30'(POLAR_EDGE) + 30'sd1, -31'sd1, 0, '{default: '0}});
    probes.push_back('{30'sd85 <<< 22, 31'sd12345, 0, '{default: '0}});
    probes.push_back('{30'sd1, 31'sd1, 0, '{default: '0}});
    probes.push_back('{-30'sd1, -31'sd1, 0, '{default: '0}});
    probes.push_back('{30'sd45 <<< 22, 31'sd90 <<< 22, 0, '{default: '0}});
    probes.push_back('{-30'sd60 <<< 22, -31'sd135 <<< 22, 0, '{default: '0}});
    probes.push_back('{30'h1555_5555, 31'h2AAA_AAAA, 0, '{default: '0}});
    probes.push_back('{30'h2AAA_AAAA, 31'h5555_5555, 0, '{default: '0}});
    foreach (probes[i]) begin
      row = probes[i];
      send_point(row.lat, row.lon, row.typed, row.pt, 1'b1);
    end

    // Random part: mostly in-range points, some raw full-width values.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      // Hold off until every owed result is in, once, to test an empty pipe.
      if (n == 300) begin
        start <= 1'b0;
        while (pending_pts.size() != 0) @(negedge clk);
      end
      gaps = !(n >= 500 && n < 800);   // long back-to-back stretch
      if ($urandom_range(0, 9) == 0) begin
        lat = 30'($urandom);
        lon = 31'($urandom);
      end else begin
        lat = 30'(int'($urandom_range(0, 2 * LAT_90)) - LAT_90);
        lon = 31'(int'($urandom_range(0, 2 * LON_180)) - LON_180);
        // Bias some points toward the polar band.
        if ($urandom_range(0, 7) == 0)
          lat = 30'(int'($urandom_range(320000000, LAT_90)) * ($urandom_range(0, 1) ? 1 : -1));
      end
      send_point(lat, lon, 1'b0, '{default: '0}, gaps);
    end
    start <= 1'b0;

    // Drain: wait out every owed result, then the pipeline depth.
    while (pending_pts.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
